@@ hdl/kps_pkg.sv @@
// shared constants, payload types and control codes of the keyframe pose sampler
`default_nettype none
package kps_pkg;

	localparam int MAX_KEYS  = 64;
	localparam int FRAC_BITS = 16;
	localparam int LANES     = 4;
	localparam int LANE_W    = $clog2(LANES);
	localparam int ROWS      = MAX_KEYS / LANES;
	localparam int ROW_W     = $clog2(ROWS);
	localparam int KEY_W     = $clog2(MAX_KEYS);
	localparam int CNT_W     = KEY_W + 1;
	localparam int SLOT_W    = 6;
	localparam int COUNT_W   = 7;
	localparam int DATA_W    = 32;
	localparam int VAL_W     = LANES * DATA_W;
	localparam int Q_W       = DATA_W + 2;
	localparam int QUO_W     = FRAC_BITS + 1;
	localparam int DIV_STEPS = FRAC_BITS + 1;
	localparam int DIVC_W    = $clog2(DIV_STEPS + 1);
	localparam int PROD_W    = DATA_W + 1 + QUO_W + 1;
	localparam int MAG_W     = 30;
	localparam int SQ_W      = 2 * MAG_W;
	localparam int SUM_W     = SQ_W + 2;
	localparam int ROOT_W    = SUM_W / 2;
	localparam int EPS_TICKS = (1 << FRAC_BITS) / 10000;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ROT_MODE  = CFG_IDX_W'(1);

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic [1:0] ST_INTERP = 2'd0;
	localparam logic [1:0] ST_HELD   = 2'd1;
	localparam logic [1:0] ST_CLAMP  = 2'd2;

	typedef struct packed {
		logic              mode;
		logic [SLOT_W-1:0] key_slot;
		logic [31:0]       sample_time;
		logic [31:0]       comp_x;
		logic [31:0]       comp_y;
		logic [31:0]       comp_z;
		logic [31:0]       comp_w;
	} cmd_t;

	typedef struct packed {
		logic [31:0]       pose_x;
		logic [31:0]       pose_y;
		logic [31:0]       pose_z;
		logic [31:0]       pose_w;
		logic [SLOT_W-1:0] segment_found;
		logic [1:0]        status;
	} result_t;

	typedef enum logic [3:0] {
		L_NOP,
		L_LOAD_A,
		L_LOAD_B,
		L_MUL,
		L_LERP,
		L_MAG,
		L_SHR,
		L_SHL,
		L_SQUARE
	} lane_op_t;

	typedef struct packed {
		lane_op_t         op;
		logic             div_start;
		logic             div_own;
		logic [31:0]      num;
		logic [31:0]      den;
		logic [QUO_W-1:0] f;
	} lane_ctrl_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRD,
		S_SCMP,
		S_VRD,
		S_VA,
		S_VB,
		S_DIV,
		S_MUL,
		S_LERP,
		S_CHK,
		S_NMAX,
		S_NSHIFT,
		S_SUM,
		S_SQS,
		S_SQRT,
		S_NDIV
	} state_t;

endpackage
`default_nettype wire

@@ hdl/kps_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none
module kps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ hdl/kps_search_lane.sv @@
// one search lane: does the query time fall inside this lane's segment
`default_nettype none
module kps_search_lane import kps_pkg::*; (
	input  wire logic        en,
	input  wire logic [31:0] lo,
	input  wire logic [31:0] hi,
	input  wire logic [31:0] t,
	output logic             hit
);

	assign hit = en && (lo <= t) && (t <= hi);

endmodule
`default_nettype wire

@@ hdl/kps_sqrt.sv @@
// iterative integer square root, one result bit per cycle
`default_nettype none
module kps_sqrt import kps_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [SUM_W-1:0]  value,
	output logic                   busy,
	output logic      [ROOT_W-1:0] root
);

	logic [SUM_W-1:0] v_q;
	logic [SUM_W-1:0] r_q;
	logic [SUM_W-1:0] bit_q;
	logic [SUM_W-1:0] trial;

	assign trial = r_q + bit_q;
	assign busy  = |bit_q;
	assign root  = r_q[ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
		end else if (start) begin
			bit_q <= SUM_W'(1) << (SUM_W - 2);
		end else if (busy) begin
			bit_q <= bit_q >> 2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= value;
			r_q <= '0;
		end else if (busy) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/kps_comp_lane.sv @@
// one component lane: lerp multiply, magnitude shifts, square and restoring divider
`default_nettype none
module kps_comp_lane import kps_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire lane_ctrl_t              ctrl,
	input  wire logic        [31:0]      comp,
	output logic             [Q_W-1:0]   q,
	output logic             [Q_W-1:0]   mag,
	output logic             [SQ_W-1:0]  sq,
	output logic             [QUO_W-1:0] quo,
	output logic                         div_busy,
	output logic             [31:0]      norm_out
);

	localparam logic [PROD_W-1:0] HALF_Q = PROD_W'(64'd1 << (FRAC_BITS - 1));

	logic [31:0]              a_q;
	logic [31:0]              b_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [Q_W-1:0]           q_q;
	logic [Q_W-1:0]           mag_q;
	logic                     neg_q;
	logic [SQ_W-1:0]          sq_q;

	logic [31:0]              rem_q;
	logic [31:0]              den_q;
	logic [QUO_W-1:0]         dvd_q;
	logic [QUO_W-1:0]         quo_q;
	logic [DIVC_W-1:0]        cnt_q;
	logic                     run_q;

	logic signed [DATA_W:0]   diff;
	logic signed [PROD_W-1:0] prod_c;
	logic signed [PROD_W-1:0] rnd;
	logic signed [PROD_W-1:0] shr;
	logic [Q_W-1:0]           q_c;
	logic [31:0]              num_v;
	logic [32:0]              rem2;
	logic                     ge;
	logic [32:0]              rem_n;

	assign diff   = $signed({b_q[31], b_q}) - $signed({a_q[31], a_q});
	assign prod_c = PROD_W'(diff) * PROD_W'($signed({1'b0, ctrl.f}));
	assign rnd    = prod_q + $signed(HALF_Q);
	assign shr    = rnd >>> FRAC_BITS;
	assign q_c    = Q_W'($signed(a_q)) + shr[Q_W-1:0];

	assign num_v = ctrl.div_own ? mag_q[31:0] : ctrl.num;
	assign rem2  = {rem_q, dvd_q[QUO_W-1]};
	assign ge    = rem2 >= {1'b0, den_q};
	assign rem_n = ge ? (rem2 - {1'b0, den_q}) : rem2;

	assign q        = q_q;
	assign mag      = mag_q;
	assign sq       = sq_q;
	assign quo      = quo_q;
	assign div_busy = run_q;
	assign norm_out = neg_q ? (32'd0 - 32'(quo_q)) : 32'(quo_q);

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			L_LOAD_A: a_q    <= comp;
			L_LOAD_B: b_q    <= comp;
			L_MUL:    prod_q <= prod_c;
			L_LERP:   q_q    <= q_c;
			L_MAG: begin
				neg_q <= q_q[Q_W-1];
				mag_q <= q_q[Q_W-1] ? (Q_W'(0) - q_q) : q_q;
			end
			L_SHR:    mag_q  <= mag_q >> 1;
			L_SHL:    mag_q  <= mag_q << 1;
			L_SQUARE: sq_q   <= SQ_W'(mag_q[MAG_W-1:0]) * SQ_W'(mag_q[MAG_W-1:0]);
			default: begin
			end
		endcase
	end

	// restoring divide of (num << FRAC_BITS) by den, num never above den
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (ctrl.div_start) begin
			run_q <= 1'b1;
			cnt_q <= DIVC_W'(DIV_STEPS);
		end else if (run_q) begin
			cnt_q <= cnt_q - DIVC_W'(1);
			if (cnt_q == DIVC_W'(1)) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.div_start) begin
			rem_q <= {1'b0, num_v[31:1]};
			dvd_q <= {num_v[0], {FRAC_BITS{1'b0}}};
			den_q <= ctrl.den;
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= rem_n[31:0];
			dvd_q <= dvd_q << 1;
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

endmodule
`default_nettype wire

@@ hdl/keyframe_pose_sampler.sv @@
// top level: keyframe tables, lane search, lerp lanes and normalize sequencer
// a query holds busy and done follows in the next cycle: the search visits
// one row of four keys at a time, then, where needed, come the weight divide,
// the normalize shift, the square root and the final lane divides; one query
// at a time
// arst_n clears control, config (key_count 2, rotation_mode 0) and the previous
// pose; key tables are undefined until loaded; done is a one-cycle strobe and
// the receiver cannot stall it
`default_nettype none
module keyframe_pose_sampler import kps_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire cmd_t                 cmd,
	output logic                      busy,
	output logic                      done,
	output result_t                   result,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data
);

	localparam logic [Q_W-1:0]   MAG_HI  = Q_W'(1) << MAG_W;
	localparam logic [Q_W-1:0]   MAG_LO  = Q_W'(1) << (MAG_W - 1);
	localparam logic [QUO_W-1:0] ONE_F   = QUO_W'(1) << FRAC_BITS;

	// config registers
	logic [COUNT_W-1:0] key_count_q;
	logic               rot_q;

	// query control
	state_t             state_q, state_d;
	logic [31:0]        t_q;
	logic [CNT_W-1:0]   n_q;
	logic [ROW_W-1:0]   row_q;
	logic [31:0]        last_q;
	logic [31:0]        t0_q;
	logic [KEY_W-1:0]   seg_q;
	logic [31:0]        lo_q;
	logic [31:0]        dur_q;
	logic               clamp_q;
	logic [Q_W-1:0]     mx_q;
	logic [SUM_W-1:0]   sum_q;

	// output beat and held pose
	logic               done_q;
	result_t            result_q;
	logic [31:0]        prev_q [LANES];

	// key tables
	logic               load_we;
	logic [LANES-1:0]   time_we;
	logic [31:0]        time_rd [LANES];
	logic [KEY_W-1:0]   val_addr;
	logic [VAL_W-1:0]   val_rd;

	// search lanes and merge
	logic [LANES-1:0]   lane_en;
	logic [LANES-1:0]   lane_hit;
	logic [31:0]        lane_lo [LANES];
	logic [CNT_W-1:0]   row_base;
	logic               last_row;
	logic               hit_any;
	logic [LANE_W-1:0]  hit_lane;
	logic [31:0]        t0_cur;
	logic [CNT_W-1:0]   n_c;

	// component lanes
	lane_ctrl_t         ctrl;
	logic [Q_W-1:0]     lane_q   [LANES];
	logic [Q_W-1:0]     lane_mag [LANES];
	logic [SQ_W-1:0]    lane_sq  [LANES];
	logic [QUO_W-1:0]   lane_quo [LANES];
	logic [LANES-1:0]   lane_busy;
	logic [31:0]        lane_norm [LANES];
	logic [QUO_W-1:0]   f_c;
	logic [Q_W-1:0]     mx_c;
	logic [SUM_W-1:0]   sum_c;

	logic               sqrt_start;
	logic               sqrt_busy;
	logic [ROOT_W-1:0]  root;

	// result staging
	logic               emit;
	logic [31:0]        emit_pose [LANES];
	logic [1:0]         emit_status;
	logic [KEY_W-1:0]   emit_seg;

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign result    = result_q;
	assign cfg_ready = 1'b1;

	// config write channel, always ready, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= COUNT_W'(2);
			rot_q       <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_KEY_COUNT) begin
				key_count_q <= cfg_data[COUNT_W-1:0];
			end else if (cfg_index == REG_ROT_MODE) begin
				rot_q <= cfg_data[0];
			end
		end
	end

	// key count forced into 2..MAX_KEYS
	always_comb begin
		if (key_count_q < COUNT_W'(2)) begin
			n_c = CNT_W'(2);
		end else if (32'(key_count_q) > MAX_KEYS) begin
			n_c = CNT_W'(MAX_KEYS);
		end else begin
			n_c = CNT_W'(key_count_q);
		end
	end

	// timestamps live in one bank per lane, slot s in bank s mod LANES
	assign load_we = start && !busy && (cmd.mode == MODE_LOAD)
		&& (32'(cmd.key_slot) < MAX_KEYS);

	for (genvar j = 0; j < LANES; j++) begin : g_time
		assign time_we[j] = load_we && (cmd.key_slot[LANE_W-1:0] == LANE_W'(j));

		kps_ram #(
			.WIDTH(32),
			.DEPTH(ROWS)
		) u_time_bank (
			.clk  (clk),
			.we   (time_we[j]),
			.waddr(cmd.key_slot[KEY_W-1:LANE_W]),
			.wdata(cmd.sample_time),
			.raddr(row_q),
			.rdata(time_rd[j])
		);
	end

	// all four components of a key in one wide word, x in the low lane
	kps_ram #(
		.WIDTH(VAL_W),
		.DEPTH(MAX_KEYS)
	) u_value_ram (
		.clk  (clk),
		.we   (load_we),
		.waddr(cmd.key_slot[KEY_W-1:0]),
		.wdata({cmd.comp_w, cmd.comp_z, cmd.comp_y, cmd.comp_x}),
		.raddr(val_addr),
		.rdata(val_rd)
	);

	// lane j of a row checks segment row*LANES + j - 1; lane 0 borrows
	// the last timestamp of the row before
	assign row_base = CNT_W'({row_q, LANE_W'(0)});
	assign last_row = (row_base + CNT_W'(LANES)) >= n_q;
	assign t0_cur   = (row_q == ROW_W'(0)) ? time_rd[0] : t0_q;

	for (genvar j = 0; j < LANES; j++) begin : g_search
		if (j == 0) begin : g_first
			assign lane_lo[j] = last_q;
		end else begin : g_rest
			assign lane_lo[j] = time_rd[j-1];
		end

		assign lane_en[j] = !((row_q == ROW_W'(0)) && (j == 0))
			&& ((row_base + CNT_W'(j)) <= (n_q - CNT_W'(1)));

		kps_search_lane u_search (
			.en (lane_en[j]),
			.lo (lane_lo[j]),
			.hi (time_rd[j]),
			.t  (t_q),
			.hit(lane_hit[j])
		);
	end

	// merge: the lowest hitting lane is the first segment in key order
	always_comb begin
		hit_any  = 1'b0;
		hit_lane = '0;
		for (int j = LANES - 1; j >= 0; j--) begin
			if (lane_hit[j]) begin
				hit_any  = 1'b1;
				hit_lane = LANE_W'(j);
			end
		end
	end

	// component lanes x, y, z, w
	for (genvar j = 0; j < LANES; j++) begin : g_comp
		kps_comp_lane u_comp (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.comp    (val_rd[j*DATA_W +: DATA_W]),
			.q       (lane_q[j]),
			.mag     (lane_mag[j]),
			.sq      (lane_sq[j]),
			.quo     (lane_quo[j]),
			.div_busy(lane_busy[j]),
			.norm_out(lane_norm[j])
		);
	end

	// weight comes from lane 0's divider, capped at one
	assign f_c = (lane_quo[0] > ONE_F) ? ONE_F : lane_quo[0];

	// merge: largest magnitude and sum of squares across lanes
	always_comb begin
		mx_c  = '0;
		sum_c = '0;
		for (int j = 0; j < LANES; j++) begin
			if (lane_mag[j] > mx_c) begin
				mx_c = lane_mag[j];
			end
			sum_c = sum_c + SUM_W'(lane_sq[j]);
		end
	end

	kps_sqrt u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sqrt_start),
		.value (sum_q),
		.busy  (sqrt_busy),
		.root  (root)
	);

	// sequencer: next state, lane commands and result staging
	always_comb begin
		state_d        = state_q;
		ctrl.op        = L_NOP;
		ctrl.div_start = 1'b0;
		ctrl.div_own   = 1'b0;
		ctrl.num       = t_q - lo_q;
		ctrl.den       = dur_q;
		ctrl.f         = f_c;
		val_addr       = seg_q;
		sqrt_start     = 1'b0;
		emit           = 1'b0;
		emit_status    = ST_INTERP;
		emit_seg       = seg_q;
		for (int j = 0; j < LANES; j++) begin
			emit_pose[j] = lane_q[j][31:0];
		end

		unique case (state_q)
			S_IDLE: begin
				if (start && (cmd.mode == MODE_QUERY)) begin
					state_d = S_SRD;
				end
			end
			S_SRD: begin
				state_d = S_SCMP;
			end
			S_SCMP: begin
				if (hit_any || last_row) begin
					state_d = S_VRD;
				end else begin
					state_d = S_SRD;
				end
			end
			S_VRD: begin
				state_d = S_VA;
			end
			S_VA: begin
				ctrl.op = L_LOAD_A;
				if (clamp_q) begin
					// end key raw, w dropped in vector mode
					emit        = 1'b1;
					emit_status = ST_CLAMP;
					for (int j = 0; j < LANES; j++) begin
						emit_pose[j] = val_rd[j*DATA_W +: DATA_W];
					end
					if (!rot_q) begin
						emit_pose[LANES-1] = '0;
					end
					state_d = S_IDLE;
				end else if (dur_q <= 32'(EPS_TICKS)) begin
					// segment too short, repeat the last pose
					emit        = 1'b1;
					emit_status = ST_HELD;
					for (int j = 0; j < LANES; j++) begin
						emit_pose[j] = prev_q[j];
					end
					state_d = S_IDLE;
				end else begin
					val_addr       = seg_q + KEY_W'(1);
					ctrl.div_start = 1'b1;
					state_d        = S_VB;
				end
			end
			S_VB: begin
				ctrl.op = L_LOAD_B;
				state_d = S_DIV;
			end
			S_DIV: begin
				if (!lane_busy[0]) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				ctrl.op = L_MUL;
				state_d = S_LERP;
			end
			S_LERP: begin
				ctrl.op = L_LERP;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (!rot_q) begin
					emit               = 1'b1;
					emit_pose[LANES-1] = '0;
					state_d            = S_IDLE;
				end else begin
					ctrl.op = L_MAG;
					state_d = S_NMAX;
				end
			end
			S_NMAX: begin
				// an all-zero quaternion passes through as zeros
				if (mx_c == '0) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_NSHIFT;
				end
			end
			S_NSHIFT: begin
				// bring the largest magnitude into [2^29, 2^30), one bit a cycle
				if (mx_q >= MAG_HI) begin
					ctrl.op = L_SHR;
				end else if (mx_q < MAG_LO) begin
					ctrl.op = L_SHL;
				end else begin
					ctrl.op = L_SQUARE;
					state_d = S_SUM;
				end
			end
			S_SUM: begin
				state_d = S_SQS;
			end
			S_SQS: begin
				sqrt_start = 1'b1;
				state_d    = S_SQRT;
			end
			S_SQRT: begin
				if (!sqrt_busy) begin
					ctrl.div_start = 1'b1;
					ctrl.div_own   = 1'b1;
					ctrl.den       = 32'(root);
					state_d        = S_NDIV;
				end
			end
			S_NDIV: begin
				if (!lane_busy[0]) begin
					emit = 1'b1;
					for (int j = 0; j < LANES; j++) begin
						emit_pose[j] = lane_norm[j];
					end
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			for (int j = 0; j < LANES; j++) begin
				prev_q[j] <= '0;
			end
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			if (emit) begin
				for (int j = 0; j < LANES; j++) begin
					prev_q[j] <= emit_pose[j];
				end
			end
		end
	end

	// datapath registers of the sequencer
	always_ff @(posedge clk) begin
		if (emit) begin
			result_q.pose_x        <= emit_pose[0];
			result_q.pose_y        <= emit_pose[1];
			result_q.pose_z        <= emit_pose[2];
			result_q.pose_w        <= emit_pose[3];
			result_q.segment_found <= SLOT_W'(emit_seg);
			result_q.status        <= emit_status;
		end

		unique case (state_q)
			S_IDLE: begin
				t_q   <= cmd.sample_time;
				n_q   <= n_c;
				row_q <= '0;
			end
			S_SCMP: begin
				if (row_q == ROW_W'(0)) begin
					t0_q <= time_rd[0];
				end
				if (hit_any) begin
					seg_q   <= KEY_W'(row_base + CNT_W'(hit_lane) - CNT_W'(1));
					lo_q    <= lane_lo[hit_lane];
					dur_q   <= time_rd[hit_lane] - lane_lo[hit_lane];
					clamp_q <= 1'b0;
				end else if (last_row) begin
					seg_q   <= (t_q < t0_cur) ? KEY_W'(0) : KEY_W'(n_q - CNT_W'(1));
					clamp_q <= 1'b1;
				end else begin
					last_q <= time_rd[LANES-1];
					row_q  <= row_q + ROW_W'(1);
				end
			end
			S_NMAX: begin
				mx_q <= mx_c;
			end
			S_NSHIFT: begin
				if (mx_q >= MAG_HI) begin
					mx_q <= mx_q >> 1;
				end else if (mx_q < MAG_LO) begin
					mx_q <= mx_q << 1;
				end
			end
			S_SUM: begin
				sum_q <= sum_c;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire
